>>> hw/rtl/msc_dg_pkg.sv
// Shared constants, types and the CRC-16 byte update for the data group parser.
`timescale 1ns / 1ps
`default_nettype none
package msc_dg_pkg;

   localparam int MAX_GROUP_BYTES = 8192;
   localparam int IDX_W = $clog2(MAX_GROUP_BYTES + 2);
   localparam int HOLD_BYTES = 8;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_XOR_OUT = 16'hFFFF;

   localparam logic [1:0] TAIL_FULL = 2'd2;

   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_HDR_SHORT  = 4'd1;
   localparam logic [3:0] ST_EXT_SHORT  = 4'd2;
   localparam logic [3:0] ST_SEG_SHORT  = 4'd3;
   localparam logic [3:0] ST_UA_SHORT   = 4'd4;
   localparam logic [3:0] ST_TID_SHORT  = 4'd5;
   localparam logic [3:0] ST_EUA_SHORT  = 4'd6;
   localparam logic [3:0] ST_NO_CRC     = 4'd7;
   localparam logic [3:0] ST_CRC_BAD    = 4'd8;
   localparam logic [3:0] ST_TOO_LONG   = 4'd9;

   localparam int PF_EXT = 0;
   localparam int PF_SEG = 1;
   localparam int PF_UA  = 2;
   localparam int PF_TID = 3;
   localparam int PF_CRC = 4;

   typedef struct packed {
      logic [IDX_W-1:0]          count;
      logic [7:0]                flags;
      logic [HOLD_BYTES-1:0][7:0] hold;
      logic [15:0]               crc;
      logic [15:0]               tail;
   } snap_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  group_type;
      logic [3:0]  continuity;
      logic [3:0]  repetition;
      logic [4:0]  present_flags;
      logic [15:0] extension_value;
      logic        segment_last;
      logic [14:0] seg_number;
      logic [15:0] tid_value;
      logic [3:0]  end_address_length;
      logic [13:0] data_offset;
      logic [13:0] data_length;
   } result_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/msc_dg_accum.sv
// Per-byte accumulation of count, header bytes, delayed tail and running CRC.
`timescale 1ns / 1ps
`default_nettype none
module msc_dg_accum
   import msc_dg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_byte,
   output snap_type        snap_next
);

   logic [IDX_W-1:0]           count_ff, count_in;
   logic [7:0]                 flags_ff, flags_in;
   logic [HOLD_BYTES-1:0][7:0] hold_ff, hold_in;
   logic [15:0]                crc_ff, crc_in;
   logic [15:0]                tail_ff, tail_in;
   logic [1:0]                 tail_cnt_ff, tail_cnt_in;

   logic [IDX_W-1:0]           count_upd;
   logic [7:0]                 flags_upd;
   logic [HOLD_BYTES-1:0][7:0] hold_upd;
   logic [15:0]                crc_upd;
   logic [15:0]                tail_upd;
   logic [1:0]                 tail_cnt_upd;

   always_comb begin
      crc_upd = (tail_cnt_ff == TAIL_FULL) ? crc16_byte(crc_ff, tail_ff[15:8]) : crc_ff;
      tail_upd = {tail_ff[7:0], data_byte};
      tail_cnt_upd = (tail_cnt_ff == TAIL_FULL) ? TAIL_FULL : tail_cnt_ff + 2'd1;
      flags_upd = (count_ff == '0) ? data_byte : flags_ff;
      for (int i = 0; i < HOLD_BYTES; i++) begin
         hold_upd[i] = (count_ff == IDX_W'(i + 1)) ? data_byte : hold_ff[i];
      end
      count_upd = (count_ff <= IDX_W'(MAX_GROUP_BYTES)) ? count_ff + 1'b1 : count_ff;

      snap_next = '{count: count_upd, flags: flags_upd, hold: hold_upd,
                    crc: crc_upd, tail: tail_upd};

      count_in = count_ff;
      flags_in = flags_ff;
      hold_in = hold_ff;
      crc_in = crc_ff;
      tail_in = tail_ff;
      tail_cnt_in = tail_cnt_ff;
      if (accept) begin
         if (last_byte) begin
            count_in = '0;
            flags_in = '0;
            hold_in = '0;
            crc_in = CRC_INIT;
            tail_in = '0;
            tail_cnt_in = '0;
         end else begin
            count_in = count_upd;
            flags_in = flags_upd;
            hold_in = hold_upd;
            crc_in = crc_upd;
            tail_in = tail_upd;
            tail_cnt_in = tail_cnt_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flags_ff <= '0;
         hold_ff <= '0;
         crc_ff <= CRC_INIT;
         tail_ff <= '0;
         tail_cnt_ff <= '0;
      end else begin
         count_ff <= count_in;
         flags_ff <= flags_in;
         hold_ff <= hold_in;
         crc_ff <= crc_in;
         tail_ff <= tail_in;
         tail_cnt_ff <= tail_cnt_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/msc_dg_decode.sv
// Header decode, length checks and CRC comparison for one finished data group.
`timescale 1ns / 1ps
`default_nettype none
module msc_dg_decode
   import msc_dg_pkg::*;
(
   input  snap_type   snap,
   output result_type result
);

   localparam int NW = IDX_W + 1;

   function automatic logic [7:0] hdr_at(input snap_type s, input logic [3:0] idx);
      logic [7:0] v;
      v = 8'h00;
      if (idx == 4'd0) begin
         v = s.flags;
      end else begin
         for (int i = 0; i < HOLD_BYTES; i++) begin
            if (idx == 4'(i + 1)) begin
               v = s.hold[i];
            end
         end
      end
      return v;
   endfunction

   logic [NW-1:0] n;
   logic [4:0]    cur;
   logic [7:0]    h0;
   logic [7:0]    h1;
   logic [7:0]    ua;
   logic [7:0]    sb;
   logic [3:0]    tb;
   logic [3:0]    nea;
   logic          done;

   always_comb begin
      result = '0;
      n = NW'(snap.count);
      cur = 5'd2;
      h0 = snap.flags;
      h1 = snap.hold[0];
      ua = 8'h00;
      sb = 8'h00;
      tb = 4'd0;
      nea = 4'd0;
      done = 1'b0;
      if (n > NW'(MAX_GROUP_BYTES)) begin
         result.status = ST_TOO_LONG;
      end else if (n < NW'(2)) begin
         result.status = ST_HDR_SHORT;
      end else begin
         result.group_type = h0[3:0];
         result.continuity = h1[7:4];
         result.repetition = h1[3:0];
         result.present_flags[PF_CRC] = h0[6];
         if (h0[7]) begin
            if (n < NW'(cur) + NW'(2)) begin
               result.status = ST_EXT_SHORT;
               done = 1'b1;
            end else begin
               result.extension_value = {hdr_at(snap, cur[3:0]), hdr_at(snap, cur[3:0] + 4'd1)};
               result.present_flags[PF_EXT] = 1'b1;
               cur = cur + 5'd2;
            end
         end
         if (!done && h0[5]) begin
            if (n < NW'(cur) + NW'(2)) begin
               result.status = ST_SEG_SHORT;
               done = 1'b1;
            end else begin
               sb = hdr_at(snap, cur[3:0]);
               result.segment_last = sb[7];
               result.seg_number = {sb[6:0], hdr_at(snap, cur[3:0] + 4'd1)};
               result.present_flags[PF_SEG] = 1'b1;
               cur = cur + 5'd2;
            end
         end
         if (!done && h0[4]) begin
            if (n < NW'(cur) + NW'(1)) begin
               result.status = ST_UA_SHORT;
               done = 1'b1;
            end else begin
               ua = hdr_at(snap, cur[3:0]);
               cur = cur + 5'd1;
               result.present_flags[PF_UA] = 1'b1;
               tb = ua[4] ? 4'd2 : 4'd0;
               if (n < NW'(cur) + NW'(tb)) begin
                  result.status = ST_TID_SHORT;
                  done = 1'b1;
               end else begin
                  if (ua[4]) begin
                     result.tid_value = {hdr_at(snap, cur[3:0]),
                                         hdr_at(snap, cur[3:0] + 4'd1)};
                     result.present_flags[PF_TID] = 1'b1;
                     cur = cur + 5'd2;
                  end
                  nea = ua[3:0] - tb;
                  if (ua[3:0] < tb || n < NW'(cur) + NW'(nea)) begin
                     result.status = ST_EUA_SHORT;
                     done = 1'b1;
                  end else begin
                     cur = cur + 5'(nea);
                     result.end_address_length = nea;
                  end
               end
            end
         end
         if (!done) begin
            if (h0[6]) begin
               if (n < NW'(cur) + NW'(2)) begin
                  result.status = ST_NO_CRC;
               end else if ((snap.crc ^ CRC_XOR_OUT) != snap.tail) begin
                  result.status = ST_CRC_BAD;
               end else begin
                  result.status = ST_OK;
                  result.data_offset = 14'(cur);
                  result.data_length = 14'(n - NW'(cur) - NW'(2));
               end
            end else begin
               result.status = ST_OK;
               result.data_offset = 14'(cur);
               result.data_length = 14'(n - NW'(cur));
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/msc_data_group_header_parser.sv
// Top level of the data group header parser: byte intake, snapshot and result registers.
`timescale 1ns / 1ps
`default_nettype none
// The parser takes one byte of a data group per cycle and, on the byte marked last,
// returns one summary item with a status code and the decoded header fields. A new
// byte can be accepted in every cycle, including the byte right after a last byte;
// the input only stalls while a summary waits in both register stages and the result
// item is not being taken. rsp_valid is set by two register stages: the snapshot
// of the group with its final CRC-16 update, loaded with the last byte, then the
// header decode and CRC comparison into the result register. Groups longer than
// MAX_GROUP_BYTES bytes are reported as too long.
module msc_data_group_header_parser
   import msc_dg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_status,
   output logic [3:0]       rsp_group_type,
   output logic [3:0]       rsp_continuity,
   output logic [3:0]       rsp_repetition,
   output logic [4:0]       rsp_present_flags,
   output logic [15:0]      rsp_extension_value,
   output logic             rsp_segment_last,
   output logic [14:0]      rsp_seg_number,
   output logic [15:0]      rsp_tid_value,
   output logic [3:0]       rsp_end_address_length,
   output logic [13:0]      rsp_data_offset,
   output logic [13:0]      rsp_data_length
);

   logic       accept;
   logic       rsp_adv;
   logic       snap_adv;
   snap_type   snap_next;
   snap_type   snap_ff, snap_in;
   logic       snap_valid_ff, snap_valid_in;
   result_type decoded;
   result_type result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign rsp_adv = !rsp_valid_ff || rsp_ready;
   assign snap_adv = !snap_valid_ff || rsp_adv;
   assign req_ready = snap_adv;
   assign accept = req_valid && req_ready;

   msc_dg_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .snap_next (snap_next)
   );

   msc_dg_decode u_decode (
      .snap   (snap_ff),
      .result (decoded)
   );

   always_comb begin
      snap_valid_in = snap_valid_ff;
      snap_in = snap_ff;
      if (snap_adv) begin
         snap_valid_in = accept && req_last_byte;
      end
      if (accept && req_last_byte) begin
         snap_in = snap_next;
      end

      rsp_valid_in = rsp_valid_ff;
      result_in = result_ff;
      if (rsp_adv) begin
         rsp_valid_in = snap_valid_ff;
         if (snap_valid_ff) begin
            result_in = decoded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = result_ff.status;
   assign rsp_group_type = result_ff.group_type;
   assign rsp_continuity = result_ff.continuity;
   assign rsp_repetition = result_ff.repetition;
   assign rsp_present_flags = result_ff.present_flags;
   assign rsp_extension_value = result_ff.extension_value;
   assign rsp_segment_last = result_ff.segment_last;
   assign rsp_seg_number = result_ff.seg_number;
   assign rsp_tid_value = result_ff.tid_value;
   assign rsp_end_address_length = result_ff.end_address_length;
   assign rsp_data_offset = result_ff.data_offset;
   assign rsp_data_length = result_ff.data_length;

endmodule
`default_nettype wire

>>> hw/rtl/msc_dg_checker.sv
// Port-level assertions for the data group header parser and their bind.
`timescale 1ns / 1ps
`default_nettype none
module msc_dg_checker
   import msc_dg_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_data_byte,
   input wire logic        req_last_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_status,
   input wire logic [3:0]  rsp_group_type,
   input wire logic [3:0]  rsp_continuity,
   input wire logic [3:0]  rsp_repetition,
   input wire logic [4:0]  rsp_present_flags,
   input wire logic [15:0] rsp_extension_value,
   input wire logic        rsp_segment_last,
   input wire logic [14:0] rsp_seg_number,
   input wire logic [15:0] rsp_tid_value,
   input wire logic [3:0]  rsp_end_address_length,
   input wire logic [13:0] rsp_data_offset,
   input wire logic [13:0] rsp_data_length
);

   // A stalled result item keeps its status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result item changed while stalled");

   // A too-long group reports nothing but its status.
   a_too_long_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_TOO_LONG |-> rsp_group_type == 4'd0 &&
      rsp_present_flags == 5'd0 && rsp_tid_value == 16'd0 && rsp_data_length == 14'd0)
      else $error("too-long group carries header fields");

   // Data offset and length are only given for a clean group.
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_data_offset == 14'd0 &&
      rsp_data_length == 14'd0)
      else $error("errored group carries data offset or length");

   // A transport id is only reported under a user access field.
   a_tid_needs_ua: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_present_flags[PF_TID] |-> rsp_present_flags[PF_UA])
      else $error("transport id without user access field");

   // Nothing can be reported in the cycle right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result item presented straight after reset");

endmodule

bind msc_data_group_header_parser msc_dg_checker u_msc_dg_checker (.*);
`default_nettype wire
